// File: design/pwa_pkg.sv
// Shared types and constants of the perspective warp address block.
// No dependencies.
package pwa_pkg;

    localparam int COEF_W  = 32;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PROD_W  = COEF_W + COORD_W + 1;
    localparam int SUM_W   = PROD_W + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_AB     = 3'd0,
        CFG_ROW0C_ROW1A = 3'd1,
        CFG_ROW1_BC     = 3'd2,
        CFG_ROW2_AB     = 3'd3,
        CFG_ROW2_C      = 3'd4,
        CFG_SRC_WIDTH   = 3'd5,
        CFG_SRC_HEIGHT  = 3'd6
    } t_cfg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;

    // h[3*row + column]
    typedef struct packed {
        t_coef [8:0] h;
    } t_coefs;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_item;

endpackage

// File: design/pwa_front.sv
// Front queue: two-word buffer that takes destination positions.
// Depends on pwa_pkg.
module pwa_front
    import pwa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);
    t_item      r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_item;
    end
endmodule

// File: design/pwa_back.sv
// Back end: projection products, sums and pipelined restoring division.
// Depends on pwa_pkg.
module pwa_back
    import pwa_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_take,
    input  t_coefs             i_coefs,
    input  logic [DIM_W-1:0]   i_width,
    input  logic [DIM_W-1:0]   i_height,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [COORD_W-1:0] o_col,
    output logic [COORD_W-1:0] o_row,
    output logic               o_inside
);
    localparam int QB = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LW = QB + 1 > DIM_W ? QB + 1 : DIM_W;
    localparam int DW = SUM_W + QB;
    localparam int NS = QB + 2;

    logic w_en;
    logic r_v_prod, r_v_sum, r_o_valid;
    logic r_v [0:NS-1];

    logic signed [PROD_W-1:0] r_p [0:5];
    logic signed [PROD_W-1:0] r_h2c, r_h2r;
    logic signed [COEF_W-1:0] r_h22;
    logic signed [SUM_W-1:0]  r_x, r_y, r_w;

    logic [SUM_W-1:0] r_rx [0:NS-1], r_ry [0:NS-1], r_dw [0:NS-1];
    logic [QB-1:0]    r_qx [0:NS-1], r_qy [0:NS-1];
    logic             r_ox [0:NS-1], r_oy [0:NS-1];
    logic             r_nx [0:NS-1], r_ny [0:NS-1], r_wz [0:NS-1];

    logic [SUM_W-1:0] n_rx [1:NS-1], n_ry [1:NS-1];
    logic [QB-1:0]    n_qx [1:NS-1], n_qy [1:NS-1];
    logic             n_ox [1:NS-1], n_oy [1:NS-1];

    logic [COORD_W-1:0] r_col, r_row;
    logic               r_inside;

    logic signed [COORD_W:0] w_c, w_r;
    logic [LW-1:0] w_lw, w_lh, w_qx, w_qy;
    logic          w_in;

    assign w_en    = !r_o_valid || i_pop;
    assign o_take  = w_en;
    assign o_empty = !r_o_valid;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_inside = r_inside;

    assign w_c = signed'({1'b0, i_item.col});
    assign w_r = signed'({1'b0, i_item.row});

    // Division steps: first checks quotient overflow, the rest find one bit each.
    always_comb begin
        for (int k = 1; k < NS; k++) begin
            logic [DW-1:0] d;
            logic [DW-1:0] rx, ry;
            d  = {{QB{1'b0}}, r_dw[k-1]} << (QB + 1 - k);
            rx = {{QB{1'b0}}, r_rx[k-1]};
            ry = {{QB{1'b0}}, r_ry[k-1]};
            n_rx[k] = r_rx[k-1];
            n_ry[k] = r_ry[k-1];
            n_qx[k] = r_qx[k-1];
            n_qy[k] = r_qy[k-1];
            n_ox[k] = r_ox[k-1];
            n_oy[k] = r_oy[k-1];
            if (k == 1) begin
                n_ox[k] = rx >= d;
                n_oy[k] = ry >= d;
            end else begin
                if (rx >= d) begin
                    n_rx[k] = SUM_W'(rx - d);
                    n_qx[k][QB+1-k] = 1'b1;
                end
                if (ry >= d) begin
                    n_ry[k] = SUM_W'(ry - d);
                    n_qy[k][QB+1-k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_lw = (LW'(i_width)  > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(i_width);
        w_lh = (LW'(i_height) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(i_height);
        w_qx = LW'(r_qx[NS-1]);
        w_qy = LW'(r_qy[NS-1]);
        w_in = !r_wz[NS-1] && !r_ox[NS-1] && !r_oy[NS-1]
            && (!r_nx[NS-1] || w_qx == '0) && (!r_ny[NS-1] || w_qy == '0)
            && w_qx < w_lw && w_qy < w_lh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod  <= 1'b0;
            r_v_sum   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v_prod  <= i_valid;
            r_v_sum   <= r_v_prod;
            r_v[0]    <= r_v_sum;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
            r_o_valid <= r_v[NS-1];
        end
        if (w_en) begin
            // Stage 1: six products
            r_p[0] <= i_coefs.h[0] * w_c;
            r_p[1] <= i_coefs.h[1] * w_r;
            r_p[2] <= i_coefs.h[3] * w_c;
            r_p[3] <= i_coefs.h[4] * w_r;
            r_h2c  <= i_coefs.h[6] * w_c;
            r_h2r  <= i_coefs.h[7] * w_r;
            r_p[4] <= PROD_W'(i_coefs.h[2]);
            r_p[5] <= PROD_W'(i_coefs.h[5]);
            r_h22  <= i_coefs.h[8];
            // Stage 2: homogeneous sums
            r_x <= SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(r_p[4]);
            r_y <= SUM_W'(r_p[2]) + SUM_W'(r_p[3]) + SUM_W'(r_p[5]);
            r_w <= SUM_W'(r_h2c) + SUM_W'(r_h2r) + SUM_W'(r_h22);
            // Stage 3: magnitudes and quotient signs
            r_rx[0] <= r_x[SUM_W-1] ? SUM_W'(-r_x) : SUM_W'(r_x);
            r_ry[0] <= r_y[SUM_W-1] ? SUM_W'(-r_y) : SUM_W'(r_y);
            r_dw[0] <= r_w[SUM_W-1] ? SUM_W'(-r_w) : SUM_W'(r_w);
            r_nx[0] <= r_x[SUM_W-1] ^ r_w[SUM_W-1];
            r_ny[0] <= r_y[SUM_W-1] ^ r_w[SUM_W-1];
            r_wz[0] <= r_w == '0;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_ox[0] <= 1'b0;
            r_oy[0] <= 1'b0;
            for (int k = 1; k < NS; k++) begin
                r_rx[k] <= n_rx[k];
                r_ry[k] <= n_ry[k];
                r_qx[k] <= n_qx[k];
                r_qy[k] <= n_qy[k];
                r_ox[k] <= n_ox[k];
                r_oy[k] <= n_oy[k];
                r_dw[k] <= r_dw[k-1];
                r_nx[k] <= r_nx[k-1];
                r_ny[k] <= r_ny[k-1];
                r_wz[k] <= r_wz[k-1];
            end
            // Output word
            r_inside <= w_in;
            r_col    <= w_in ? COORD_W'(w_qx) : '0;
            r_row    <= w_in ? COORD_W'(w_qy) : '0;
        end
    end
endmodule

// File: design/perspective_warp_address.sv
// Perspective warp address generator: top level with configuration registers.
// Stages: products, sums, magnitudes, division steps and output word.
// Throughput: one word per cycle unless the output is held; the restoring divider
// finds one quotient bit per stage, so its depth sets the latency, not the rate.
// Reset (synchronous, active low): identity matrix, 4096 x 4096 source, queues empty.
// Depends on pwa_pkg, pwa_front, pwa_back.
module perspective_warp_address
    import pwa_pkg::*;
#(
    parameter int MAX_DIM        = 4096,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_W-1:0]    i_dest_col,
    input  logic [COORD_W-1:0]    i_dest_row,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_W-1:0]    o_source_col,
    output logic [COORD_W-1:0]    o_source_row,
    output logic                  o_inside_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam logic [COEF_W-1:0] ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

    logic [CFG_DATA_W-1:0] r_row0_ab, r_row0c_row1a, r_row1_bc, r_row2_ab;
    logic [COEF_W-1:0]     r_row2_c;
    logic [DIM_W-1:0]      r_width, r_height;
    t_coefs                w_coefs;
    t_item                 w_in_item, w_q_item;
    logic                  w_q_valid, w_take;

    // Registers are always ready; unknown indexes drop the word.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_ab     <= {{COEF_W{1'b0}}, ONE};
            r_row0c_row1a <= '0;
            r_row1_bc     <= {{COEF_W{1'b0}}, ONE};
            r_row2_ab     <= '0;
            r_row2_c      <= ONE;
            r_width       <= DIM_W'(4096);
            r_height      <= DIM_W'(4096);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0_AB:     r_row0_ab     <= i_cfg_data;
                CFG_ROW0C_ROW1A: r_row0c_row1a <= i_cfg_data;
                CFG_ROW1_BC:     r_row1_bc     <= i_cfg_data;
                CFG_ROW2_AB:     r_row2_ab     <= i_cfg_data;
                CFG_ROW2_C:      r_row2_c      <= i_cfg_data[COEF_W-1:0];
                CFG_SRC_WIDTH:   r_width       <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:  r_height      <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the coefficient pairs: low half first.
    assign w_coefs.h[0] = r_row0_ab[31:0];
    assign w_coefs.h[1] = r_row0_ab[63:32];
    assign w_coefs.h[2] = r_row0c_row1a[31:0];
    assign w_coefs.h[3] = r_row0c_row1a[63:32];
    assign w_coefs.h[4] = r_row1_bc[31:0];
    assign w_coefs.h[5] = r_row1_bc[63:32];
    assign w_coefs.h[6] = r_row2_ab[31:0];
    assign w_coefs.h[7] = r_row2_ab[63:32];
    assign w_coefs.h[8] = r_row2_c;

    assign w_in_item.col = i_dest_col;
    assign w_in_item.row = i_dest_row;

    pwa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_in_item),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_take  (w_take)
    );

    pwa_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_take   (w_take),
        .i_coefs  (w_coefs),
        .i_width  (r_width),
        .i_height (r_height),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_col    (o_source_col),
        .o_row    (o_source_row),
        .o_inside (o_inside_res)
    );
endmodule
